FILE: src/pcu_pkg.sv
// Shared types, constants and helpers for the PID controller update block.
// Used by the sequencer, datapath, multiplier and top level.
// No dependencies.
package pcu_pkg;

  // Number formats
  localparam int DATA_W    = 32;                 // Q16.16 values and gains
  localparam int FRAC_BITS = 16;                 // fraction bits of values and gains
  localparam int DT_W      = 16;                 // sample interval width
  localparam int DT_FRAC   = 8;                  // sample interval is Q8.8
  localparam int LIMIT_W   = 31;                 // integral bound width
  localparam int CFG_IDX_W = 3;

  // Shared multiplier: signed operands one bit wider than the data, so the
  // unsigned interval fits as a positive operand
  localparam int MUL_W  = DATA_W + 1;
  localparam int PROD_W = 2 * MUL_W;
  // Running sum of two shifted products and the integral
  localparam int ACC_W  = PROD_W - FRAC_BITS + 2;

  // Derivative divider: magnitude of (error difference * 256), two
  // quotient bits per iteration
  localparam int DVD_W     = DATA_W + DT_FRAC;
  localparam int DIV_ITERS = DVD_W / 2;
  localparam int CNT_W     = $clog2(DIV_ITERS);

  // Microprogram counter
  localparam int PC_W = 4;

  // Derivative gain reset: 150.0, saturated if the format cannot hold it
  localparam longint unsigned GAIN_D_RAW = 64'd150 << FRAC_BITS;
  localparam logic [DATA_W-1:0] GAIN_D_RESET =
      (GAIN_D_RAW > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(GAIN_D_RAW);

  localparam logic [DT_W-1:0] DT_RESET = 16'd256;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT        = 3'd0,
    REG_GAIN_P          = 3'd1,
    REG_GAIN_I          = 3'd2,
    REG_GAIN_D          = 3'd3,
    REG_INTEGRAL_LIMIT  = 3'd4,
    REG_SAMPLE_INTERVAL = 3'd5
  } reg_idx_t;

  // Datapath operation of one microinstruction
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,     // take a measurement, form the saturated error
    OP_STEP,       // saturate error*dt >> 8 into the integral step
    OP_INTEG,      // add scaled step to the integral and clamp
    OP_DIV_INIT,   // load the derivative divider
    OP_DIV_STEP,   // two quotient bits
    OP_DIV_FIN,    // sign and saturate the derivative
    OP_ACC_P,      // proportional term plus integral
    OP_FINISH      // add derivative term, saturate, hand off the result
  } op_t;

  // Operand pairing for the shared multiplier
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_ERR_DT,
    MUL_STEP_GI,
    MUL_GP_ERR,
    MUL_GD_DERIV
  } mul_t;

  // Jump condition: when true, the counter loads the target
  typedef enum logic [1:0] {
    COND_NEXT,
    COND_NO_IN,
    COND_DIV_MORE,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t             op;
    mul_t            mul;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic div_more;
    logic out_busy;
  } status_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] val;
  } sat_t;

  // Saturate a wide signed value to the 32-bit signed range
  function automatic sat_t sat32(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] max_w;
    logic signed [PROD_W-1:0] min_w;
    sat_t r;
    max_w = {{(PROD_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    min_w = {{(PROD_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
    if (v > max_w) begin
      r.hit = 1'b1;
      r.val = max_w[DATA_W-1:0];
    end else if (v < min_w) begin
      r.hit = 1'b1;
      r.val = min_w[DATA_W-1:0];
    end else begin
      r.hit = 1'b0;
      r.val = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: src/pcu_seq.sv
// Microcode sequencer: program ROM, step counter and conditional jumps.
// Depends on pcu_pkg for the control word and status types.
module pcu_seq
  import pcu_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  status_t status,
  output ctrl_t   ctrl
);

  localparam logic [PC_W-1:0] STEP_IDLE     = 4'd0;
  localparam logic [PC_W-1:0] STEP_MUL_DT   = 4'd1;
  localparam logic [PC_W-1:0] STEP_SAT_STEP = 4'd2;
  localparam logic [PC_W-1:0] STEP_MUL_GI   = 4'd3;
  localparam logic [PC_W-1:0] STEP_INTEG    = 4'd4;
  localparam logic [PC_W-1:0] STEP_DIV_INIT = 4'd5;
  localparam logic [PC_W-1:0] STEP_DIV_LOOP = 4'd6;
  localparam logic [PC_W-1:0] STEP_DIV_FIN  = 4'd7;
  localparam logic [PC_W-1:0] STEP_ACC_P    = 4'd8;
  localparam logic [PC_W-1:0] STEP_FINISH   = 4'd9;
  localparam logic [PC_W-1:0] LAST_STEP     = STEP_FINISH;

  // Program ROM, one control word per step
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t cw;
    cw = '{op: OP_NOP, mul: MUL_NONE, cond: COND_NEXT, target: STEP_IDLE};
    case (pc)
      STEP_IDLE:     cw = '{op: OP_ACCEPT,   mul: MUL_NONE,     cond: COND_NO_IN,
                            target: STEP_IDLE};
      STEP_MUL_DT:   cw = '{op: OP_NOP,      mul: MUL_ERR_DT,   cond: COND_NEXT,
                            target: STEP_IDLE};
      STEP_SAT_STEP: cw = '{op: OP_STEP,     mul: MUL_NONE,     cond: COND_NEXT,
                            target: STEP_IDLE};
      STEP_MUL_GI:   cw = '{op: OP_NOP,      mul: MUL_STEP_GI,  cond: COND_NEXT,
                            target: STEP_IDLE};
      STEP_INTEG:    cw = '{op: OP_INTEG,    mul: MUL_NONE,     cond: COND_NEXT,
                            target: STEP_IDLE};
      STEP_DIV_INIT: cw = '{op: OP_DIV_INIT, mul: MUL_NONE,     cond: COND_NEXT,
                            target: STEP_IDLE};
      STEP_DIV_LOOP: cw = '{op: OP_DIV_STEP, mul: MUL_NONE,     cond: COND_DIV_MORE,
                            target: STEP_DIV_LOOP};
      STEP_DIV_FIN:  cw = '{op: OP_DIV_FIN,  mul: MUL_GP_ERR,   cond: COND_NEXT,
                            target: STEP_IDLE};
      STEP_ACC_P:    cw = '{op: OP_ACC_P,    mul: MUL_GD_DERIV, cond: COND_NEXT,
                            target: STEP_IDLE};
      STEP_FINISH:   cw = '{op: OP_FINISH,   mul: MUL_NONE,     cond: COND_OUT_BUSY,
                            target: STEP_FINISH};
      default:       cw = '{op: OP_NOP,      mul: MUL_NONE,     cond: COND_NEXT,
                            target: STEP_IDLE};
    endcase
    return cw;
  endfunction

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  logic            taken;

  assign ctrl = ucode(pc_r);

  // Evaluate the jump condition of the current word
  always_comb begin
    case (ctrl.cond)
      COND_NEXT:     taken = 1'b0;
      COND_NO_IN:    taken = !status.in_valid;
      COND_DIV_MORE: taken = status.div_more;
      COND_OUT_BUSY: taken = status.out_busy;
      default:       taken = 1'b0;
    endcase
  end

  // Jump, wrap after the last step, or advance
  always_comb begin
    if (taken) begin
      pc_nxt = ctrl.target;
    end else if (pc_r == LAST_STEP) begin
      pc_nxt = STEP_IDLE;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

FILE: src/pcu_mul.sv
// Shared signed multiplier with a registered product.
// Depends on pcu_pkg for operand and product widths.
module pcu_mul
  import pcu_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] prod
);

  logic signed [PROD_W-1:0] prod_r;

  // Load a new product only when a step asks for one
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
    end
  end

  assign prod = prod_r;

endmodule

FILE: src/pcu_dp.sv
// Datapath: configuration registers, controller state, divider, result
// register. Driven by the sequencer control word; depends on pcu_pkg.
module pcu_dp
  import pcu_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  ctrl_t                    ctrl,
  output status_t                  status,
  // configuration
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_wdata,
  // input channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] in_measurement,
  // result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_drive,
  output logic                     out_integral_clamped,
  output logic                     out_drive_saturated,
  // shared multiplier
  output logic                     mul_en,
  output logic signed [MUL_W-1:0]  mul_a,
  output logic signed [MUL_W-1:0]  mul_b,
  input  logic signed [PROD_W-1:0] mul_prod
);

  // Configuration and persistent state
  logic signed [DATA_W-1:0] setpoint_r;
  logic signed [DATA_W-1:0] gain_p_r;
  logic signed [DATA_W-1:0] gain_i_r;
  logic signed [DATA_W-1:0] gain_d_r;
  logic [LIMIT_W-1:0]       integral_limit_r;
  logic [DT_W-1:0]          sample_interval_r;
  logic signed [DATA_W-1:0] integral_sum_r;
  logic signed [DATA_W-1:0] last_error_r;
  logic                     out_valid_r;

  // Per-item working registers
  logic signed [DATA_W-1:0] err_r,     err_nxt;
  logic signed [DATA_W-1:0] step_r,    step_nxt;
  logic signed [DATA_W-1:0] integ_r,   integ_nxt;
  logic                     clamp_r,   clamp_nxt;
  logic signed [DATA_W-1:0] deriv_r,   deriv_nxt;
  logic signed [ACC_W-1:0]  acc_r,     acc_nxt;
  logic [DVD_W-1:0]         quo_r,     quo_nxt;
  logic [DT_W-1:0]          rem_r,     rem_nxt;
  logic [DT_W-1:0]          div_r,     div_nxt;
  logic                     neg_r,     neg_nxt;
  logic [CNT_W-1:0]         cnt_r,     cnt_nxt;
  logic signed [DATA_W-1:0] drive_r,   drive_nxt;
  logic                     oclamp_r,  oclamp_nxt;
  logic                     osat_r,    osat_nxt;

  logic                     in_xfer;
  logic                     out_busy;
  logic                     finish_go;

  // Arithmetic temporaries
  logic signed [DATA_W:0]   err_diff;
  logic signed [DATA_W:0]   d_diff;
  logic signed [DATA_W:0]   d_mag;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [PROD_W-1:0] integ_wide;
  logic signed [PROD_W-1:0] lim_pos;
  logic signed [PROD_W-1:0] lim_neg;
  logic signed [PROD_W-1:0] total;
  logic signed [DVD_W+1:0]  q_mag;
  logic signed [DVD_W+1:0]  q_sgn;
  logic [DT_W:0]            t1, t2, r1, r2;
  logic                     ge1, ge2;
  sat_t                     err_sat, step_sat, deriv_sat, total_sat;

  assign in_ready  = (ctrl.op == OP_ACCEPT);
  assign in_xfer   = in_valid && in_ready;
  assign out_busy  = out_valid_r && !out_ready;
  assign finish_go = (ctrl.op == OP_FINISH) && !out_busy;

  assign status.in_valid = in_valid;
  assign status.div_more = (cnt_r != CNT_W'(DIV_ITERS - 1));
  assign status.out_busy = out_busy;

  // Route operands to the shared multiplier
  always_comb begin
    mul_en = (ctrl.mul != MUL_NONE);
    mul_a  = '0;
    mul_b  = '0;
    case (ctrl.mul)
      MUL_ERR_DT: begin
        mul_a = MUL_W'(err_r);
        mul_b = {{(MUL_W-DT_W){1'b0}}, sample_interval_r};
      end
      MUL_STEP_GI: begin
        mul_a = MUL_W'(step_r);
        mul_b = MUL_W'(gain_i_r);
      end
      MUL_GP_ERR: begin
        mul_a = MUL_W'(gain_p_r);
        mul_b = MUL_W'(err_r);
      end
      MUL_GD_DERIV: begin
        mul_a = MUL_W'(gain_d_r);
        mul_b = MUL_W'(deriv_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Shared arithmetic terms
  always_comb begin
    err_diff   = (DATA_W+1)'(setpoint_r) - (DATA_W+1)'(in_measurement);
    err_sat    = sat32(PROD_W'(err_diff));
    step_sat   = sat32(mul_prod >>> DT_FRAC);
    prod_sh    = mul_prod >>> FRAC_BITS;
    integ_wide = prod_sh + PROD_W'(integral_sum_r);
    lim_pos    = PROD_W'($signed({1'b0, integral_limit_r}));
    lim_neg    = -lim_pos;
    d_diff     = (DATA_W+1)'(err_r) - (DATA_W+1)'(last_error_r);
    d_mag      = d_diff[DATA_W] ? -d_diff : d_diff;
    q_mag      = $signed({2'b00, quo_r});
    q_sgn      = neg_r ? -q_mag : q_mag;
    deriv_sat  = sat32(PROD_W'(q_sgn));
    total      = PROD_W'(acc_r) + prod_sh;
    total_sat  = sat32(total);
    // two restoring quotient bits
    t1  = {rem_r, quo_r[DVD_W-1]};
    ge1 = (t1 >= {1'b0, div_r});
    r1  = ge1 ? (t1 - {1'b0, div_r}) : t1;
    t2  = {r1[DT_W-1:0], quo_r[DVD_W-2]};
    ge2 = (t2 >= {1'b0, div_r});
    r2  = ge2 ? (t2 - {1'b0, div_r}) : t2;
  end

  // Next values of the working registers, one operation per step
  always_comb begin
    err_nxt    = err_r;
    step_nxt   = step_r;
    integ_nxt  = integ_r;
    clamp_nxt  = clamp_r;
    deriv_nxt  = deriv_r;
    acc_nxt    = acc_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    div_nxt    = div_r;
    neg_nxt    = neg_r;
    cnt_nxt    = cnt_r;
    drive_nxt  = drive_r;
    oclamp_nxt = oclamp_r;
    osat_nxt   = osat_r;
    case (ctrl.op)
      OP_ACCEPT: begin
        if (in_xfer) begin
          err_nxt = err_sat.val;
        end
      end
      OP_STEP: begin
        step_nxt = step_sat.val;
      end
      OP_INTEG: begin
        if (integ_wide > lim_pos) begin
          integ_nxt = lim_pos[DATA_W-1:0];
          clamp_nxt = 1'b1;
        end else if (integ_wide < lim_neg) begin
          integ_nxt = lim_neg[DATA_W-1:0];
          clamp_nxt = 1'b1;
        end else begin
          integ_nxt = integ_wide[DATA_W-1:0];
          clamp_nxt = 1'b0;
        end
      end
      OP_DIV_INIT: begin
        quo_nxt = {d_mag[DATA_W-1:0], {DT_FRAC{1'b0}}};
        rem_nxt = '0;
        neg_nxt = d_diff[DATA_W];
        cnt_nxt = '0;
        // a zero interval divides by one
        div_nxt = (sample_interval_r == '0) ? DT_W'(1) : sample_interval_r;
      end
      OP_DIV_STEP: begin
        quo_nxt = {quo_r[DVD_W-3:0], ge1, ge2};
        rem_nxt = r2[DT_W-1:0];
        cnt_nxt = cnt_r + 1'b1;
      end
      OP_DIV_FIN: begin
        deriv_nxt = deriv_sat.val;
      end
      OP_ACC_P: begin
        acc_nxt = ACC_W'(prod_sh) + ACC_W'(integ_r);
      end
      OP_FINISH: begin
        if (finish_go) begin
          drive_nxt  = total_sat.val;
          osat_nxt   = total_sat.hit;
          oclamp_nxt = clamp_r;
        end
      end
      default: begin
        err_nxt = err_r;
      end
    endcase
  end

  // Hold working and result payload
  always_ff @(posedge clk) begin
    err_r    <= err_nxt;
    step_r   <= step_nxt;
    integ_r  <= integ_nxt;
    clamp_r  <= clamp_nxt;
    deriv_r  <= deriv_nxt;
    acc_r    <= acc_nxt;
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    div_r    <= div_nxt;
    neg_r    <= neg_nxt;
    cnt_r    <= cnt_nxt;
    drive_r  <= drive_nxt;
    oclamp_r <= oclamp_nxt;
    osat_r   <= osat_nxt;
  end

  // Configuration writes, controller state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r        <= '0;
      gain_p_r          <= '0;
      gain_i_r          <= '0;
      gain_d_r          <= GAIN_D_RESET;
      integral_limit_r  <= '0;
      sample_interval_r <= DT_RESET;
      integral_sum_r    <= '0;
      last_error_r      <= '0;
      out_valid_r       <= 1'b0;
    end else begin
      // commit the new state when the result is handed off
      if (finish_go) begin
        integral_sum_r <= integ_r;
        last_error_r   <= err_r;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_SETPOINT: begin
            setpoint_r <= cfg_wdata;
          end
          REG_GAIN_P: begin
            gain_p_r       <= cfg_wdata;
            integral_sum_r <= '0;
            last_error_r   <= '0;
          end
          REG_GAIN_I: begin
            gain_i_r       <= cfg_wdata;
            integral_sum_r <= '0;
            last_error_r   <= '0;
          end
          REG_GAIN_D: begin
            gain_d_r       <= cfg_wdata;
            integral_sum_r <= '0;
            last_error_r   <= '0;
          end
          REG_INTEGRAL_LIMIT: begin
            integral_limit_r <= cfg_wdata[LIMIT_W-1:0];
            integral_sum_r   <= '0;
            last_error_r     <= '0;
          end
          REG_SAMPLE_INTERVAL: begin
            sample_interval_r <= cfg_wdata[DT_W-1:0];
          end
          default: begin
            setpoint_r <= setpoint_r;
          end
        endcase
      end
      // advance the result register
      if (finish_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_drive            = drive_r;
  assign out_integral_clamped = oclamp_r;
  assign out_drive_saturated  = osat_r;

endmodule

FILE: src/pid_controller_update.sv
// PID controller update: top level joining sequencer, datapath and multiplier.
// Depends on pcu_pkg, pcu_seq, pcu_dp and pcu_mul.
//
// Usage:
//   Configuration is written through cfg_we / cfg_index / cfg_wdata, one
//   register per cycle, while no measurement is in flight. Writing a gain
//   or the integral limit clears the integral and the stored error.
//   Each measurement is one transfer on in_valid / in_ready and produces
//   exactly one result transfer on out_valid / out_ready carrying the
//   saturated drive and the clamp and saturation flags.
//   An item passes through ten microcode steps from its input transfer to
//   its result being valid; one of them repeats while the serial divider
//   forms the derivative two quotient bits per cycle.
//   The next measurement can be taken in the cycle after the previous result
//   is loaded, and not while an item is still being processed.
//   The result sits in an output register; while the receiver stalls the
//   block still takes and processes the next measurement, then holds on
//   its final step until the output register is free.
//   Synchronous active-low reset returns the registers to their defaults
//   (derivative gain 150.0, interval 1.0) and clears the controller state.
module pid_controller_update
  import pcu_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] in_measurement,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_drive,
  output logic                     out_integral_clamped,
  output logic                     out_drive_saturated
);

  ctrl_t                    ctrl;
  status_t                  status;
  logic                     mul_en;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_prod;

  pcu_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  pcu_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_prod)
  );

  pcu_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .ctrl                 (ctrl),
    .status               (status),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_measurement       (in_measurement),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_drive            (out_drive),
    .out_integral_clamped (out_integral_clamped),
    .out_drive_saturated  (out_drive_saturated),
    .mul_en               (mul_en),
    .mul_a                (mul_a),
    .mul_b                (mul_b),
    .mul_prod             (mul_prod)
  );

endmodule

FILE: bench/pcu_drive_checker.sv
`timescale 1ns / 100ps
// Checker for the PID controller update block: follows register writes,
// predicts the drive result of every measurement and compares output transfers.
// Depends on pcu_pkg for widths, the fraction format and register indexes.
module pcu_drive_checker
  import pcu_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_wdata,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic signed [DATA_W-1:0] in_measurement,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic signed [DATA_W-1:0] out_drive,
  input  logic                     out_integral_clamped,
  input  logic                     out_drive_saturated,
  output int                       mismatch_count,
  output int                       results_pending
);

  localparam longint WORD_HI       = 64'sh7FFF_FFFF;
  localparam longint WORD_LO       = -WORD_HI - 1;
  localparam longint DERIV_SCALE   = longint'(1) << DT_FRAC;
  localparam longint KD_RESET_UNITS = 150;
  localparam longint KD_RAW        = KD_RESET_UNITS << FRAC_BITS;
  localparam longint KD_RESET      = (KD_RAW > WORD_HI) ? WORD_HI : KD_RAW;
  localparam longint DT_DEFAULT    = 256;

  typedef struct {
    logic signed [DATA_W-1:0] drive;
    logic                     clamped;
    logic                     saturated;
  } drive_rec_t;

  // Controller registers and state as the block should hold them
  longint             setpoint_r;
  longint             kp_r;
  longint             ki_r;
  longint             kd_r;
  longint             limit_r;
  logic [DT_W-1:0]    dt_r;
  longint             integ_r;
  longint             last_err_r;
  drive_rec_t         drive_expect_q[$];

  function automatic longint clip32(input longint v);
    if (v > WORD_HI) return WORD_HI;
    if (v < WORD_LO) return WORD_LO;
    return v;
  endfunction

  // Advance the controller by one tick and queue the drive it must produce
  task automatic predict_drive(input logic signed [DATA_W-1:0] meas);
    longint     err;
    longint     dt;
    longint     divisor;
    longint     step;
    longint     integ;
    longint     deriv;
    longint     total;
    drive_rec_t rec;
    dt      = longint'(dt_r);
    divisor = (dt == 0) ? 1 : dt;
    err     = clip32(setpoint_r - longint'(meas));

    // Integral: error*dt back to Q16.16, scaled by the gain, then clamped
    step  = clip32((err * dt) >>> DT_FRAC);
    integ = integ_r + ((step * ki_r) >>> FRAC_BITS);
    rec.clamped = 1'b0;
    if (integ > limit_r) begin
      integ       = limit_r;
      rec.clamped = 1'b1;
    end else if (integ < -limit_r) begin
      integ       = -limit_r;
      rec.clamped = 1'b1;
    end

    // Derivative divides toward zero; a zero interval divides by one
    deriv = clip32(((err - last_err_r) * DERIV_SCALE) / divisor);

    // Sum the terms exactly, saturate once
    total = ((kp_r * err) >>> FRAC_BITS) + ((kd_r * deriv) >>> FRAC_BITS) + integ;
    rec.saturated = (total != clip32(total));
    rec.drive     = 32'(clip32(total));

    integ_r    = integ;
    last_err_r = err;
    drive_expect_q.push_back(rec);
  endtask

  // Compare one result transfer against the oldest prediction
  task automatic check_drive();
    drive_rec_t want;
    if (drive_expect_q.size() == 0) begin
      $error("drive: result transfer with no measurement pending, actual %0d", out_drive);
      mismatch_count++;
    end else begin
      want = drive_expect_q.pop_front();
      if (out_drive !== want.drive) begin
        $error("drive: expected %0d, actual %0d", want.drive, out_drive);
        mismatch_count++;
      end
      if (out_integral_clamped !== want.clamped) begin
        $error("integral_clamped: expected %0b, actual %0b", want.clamped,
               out_integral_clamped);
        mismatch_count++;
      end
      if (out_drive_saturated !== want.saturated) begin
        $error("drive_saturated: expected %0b, actual %0b", want.saturated,
               out_drive_saturated);
        mismatch_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    logic wipe;
    wipe = 1'b0;
    if (!rst_n) begin
      setpoint_r = 0;
      kp_r       = 0;
      ki_r       = 0;
      kd_r       = KD_RESET;
      limit_r    = 0;
      dt_r       = DT_W'(DT_DEFAULT);
      integ_r    = 0;
      last_err_r = 0;
      drive_expect_q.delete();
    end else begin
      // Track register writes; gains and the limit clear the controller state
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_SETPOINT: setpoint_r = longint'($signed(cfg_wdata));
          REG_GAIN_P: begin
            kp_r = longint'($signed(cfg_wdata));
            wipe = 1'b1;
          end
          REG_GAIN_I: begin
            ki_r = longint'($signed(cfg_wdata));
            wipe = 1'b1;
          end
          REG_GAIN_D: begin
            kd_r = longint'($signed(cfg_wdata));
            wipe = 1'b1;
          end
          REG_INTEGRAL_LIMIT: begin
            limit_r = longint'(cfg_wdata[LIMIT_W-1:0]);
            wipe    = 1'b1;
          end
          REG_SAMPLE_INTERVAL: dt_r = cfg_wdata[DT_W-1:0];
          default: ;
        endcase
        if (wipe) begin
          integ_r    = 0;
          last_err_r = 0;
        end
      end
      if (in_valid && in_ready) predict_drive(in_measurement);
      if (out_valid && out_ready) check_drive();
    end
    results_pending = drive_expect_q.size();
  end

endmodule

FILE: bench/tb_pid_controller_update.sv
`timescale 1ns / 100ps
// Testbench top for pid_controller_update: clock, reset, register programming,
// measurement and stall stimulus, watchdog and verdict. Depends on pcu_pkg,
// the block itself and pcu_drive_checker, which predicts and compares.
module tb_pid_controller_update;
  import pcu_pkg::*;

  localparam int HALF_PERIOD    = 4;
  localparam int RESET_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 40;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_ITEMS    = 78;

  // Register indexes the block does not decode
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // Receiver behavior
  localparam int READY_ALWAYS = 0;
  localparam int READY_COIN   = 1;
  localparam int READY_STALLS = 2;

  localparam logic [DATA_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] WORD_NEG = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0] Q_ONE    = 32'h0001_0000;

  logic                     clk            = 1'b0;
  logic                     rst_n          = 1'b0;
  logic                     cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index      = '0;
  logic [DATA_W-1:0]        cfg_wdata      = '0;
  logic                     in_valid       = 1'b0;
  logic signed [DATA_W-1:0] in_measurement = '0;
  logic                     out_ready      = 1'b0;
  logic                     in_ready;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_drive;
  logic                     out_integral_clamped;
  logic                     out_drive_saturated;

  int mismatch_count;
  int results_pending;
  int burst_left   = 0;
  int idle_cycles  = 0;
  int ready_mode   = READY_ALWAYS;
  int mode_cycles  = 0;
  int stall_cycles = 0;

  logic [DATA_W-1:0]        setpoint_now = '0;
  logic signed [DATA_W-1:0] meas_walk    = '0;

  always #HALF_PERIOD clk = ~clk;

  pid_controller_update dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_measurement       (in_measurement),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_drive            (out_drive),
    .out_integral_clamped (out_integral_clamped),
    .out_drive_saturated  (out_drive_saturated)
  );

  pcu_drive_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_measurement       (in_measurement),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_drive            (out_drive),
    .out_integral_clamped (out_integral_clamped),
    .out_drive_saturated  (out_drive_saturated),
    .mismatch_count       (mismatch_count),
    .results_pending      (results_pending)
  );

  // Receiver: switch between always ready, coin flips and long stalls
  always @(negedge clk) begin
    if (mode_cycles == 0) begin
      ready_mode  = $urandom_range(READY_ALWAYS, READY_STALLS);
      mode_cycles = $urandom_range(50, 400);
    end
    mode_cycles--;
    if (stall_cycles > 0) begin
      stall_cycles--;
      out_ready <= 1'b0;
    end else begin
      case (ready_mode)
        READY_ALWAYS: out_ready <= 1'b1;
        READY_COIN:   out_ready <= 1'($urandom_range(0, 1));
        default: begin
          if ($urandom_range(0, 7) == 0) begin
            stall_cycles = $urandom_range(1, 60);
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Hold a register write for one cycle; the enable stays up for the next write
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == REG_SETPOINT) setpoint_now = data;
    @(negedge clk);
  endtask

  task automatic cfg_release();
    cfg_we <= 1'b0;
  endtask

  // Send one measurement; bursts keep valid up, gaps drop it
  task automatic send_measurement(input logic [DATA_W-1:0] meas);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 40)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
    end
    in_valid       <= 1'b1;
    in_measurement <= meas;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    if (burst_left == 0) in_valid <= 1'b0;
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain();
    if (burst_left != 0) in_valid <= 1'b0;
    burst_left = 0;
    while (results_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_extreme();
    case ($urandom_range(0, 3))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2:       return '0;
      default: return WORD_NEG;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_setpoint();
    case ($urandom_range(0, 5))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2:       return $urandom;
      default: return int'($urandom_range(0, 200 * 65536)) - 100 * 65536;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2:       return '0;
      3:       return $urandom;
      default: return int'($urandom_range(0, 2**19)) - 2**18;
    endcase
  endfunction

  // Bit 31 lies above the register and is random to exercise masking
  function automatic logic [DATA_W-1:0] pick_limit();
    logic [DATA_W-1:0] w;
    w = $urandom;
    case ($urandom_range(0, 4))
      0:       w[LIMIT_W-1:0] = '1;
      1:       w[LIMIT_W-1:0] = '0;
      2:       ;
      default: w[LIMIT_W-1:0] = LIMIT_W'($urandom_range(0, 2**22));
    endcase
    return w;
  endfunction

  function automatic logic [DATA_W-1:0] pick_interval();
    logic [DATA_W-1:0] w;
    w = $urandom;
    case ($urandom_range(0, 7))
      0:       w[DT_W-1:0] = '0;
      1:       w[DT_W-1:0] = 16'd1;
      2:       w[DT_W-1:0] = '1;
      3:       w[DT_W-1:0] = 16'd256;
      4:       ;
      default: w[DT_W-1:0] = DT_W'($urandom_range(16, 1024));
    endcase
    return w;
  endfunction

  // Mostly a slow drift around the setpoint, with jumps and extremes mixed in
  function automatic logic [DATA_W-1:0] next_measurement();
    int pick;
    pick = $urandom_range(0, 19);
    case (pick)
      0: return $urandom;
      1: return pick_extreme();
      2: begin
        meas_walk = setpoint_now + (int'($urandom_range(0, 2**23)) - 2**22);
        return meas_walk;
      end
      default: begin
        meas_walk = meas_walk + (int'($urandom_range(0, 2**17)) - 2**16);
        return meas_walk;
      end
    endcase
  endfunction

  // Reprogram a random subset of the registers while the block is idle
  task automatic random_settings();
    drain();
    if ($urandom_range(0, 2) != 0) cfg_write(REG_SETPOINT, pick_setpoint());
    if ($urandom_range(0, 2) != 0) cfg_write(REG_GAIN_P, pick_gain());
    if ($urandom_range(0, 2) != 0) cfg_write(REG_GAIN_I, pick_gain());
    if ($urandom_range(0, 2) != 0) cfg_write(REG_GAIN_D, pick_gain());
    if ($urandom_range(0, 2) != 0) cfg_write(REG_INTEGRAL_LIMIT, pick_limit());
    if ($urandom_range(0, 2) != 0) cfg_write(REG_SAMPLE_INTERVAL, pick_interval());
    if ($urandom_range(0, 3) == 0)
      cfg_write($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
    cfg_release();
    meas_walk = setpoint_now;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Reset defaults: derivative gain 150.0, unit interval, error extremes
    send_measurement('0);
    send_measurement(WORD_MAX);
    send_measurement(WORD_MIN);
    send_measurement(Q_ONE);
    send_measurement(-Q_ONE);
    send_measurement(WORD_NEG);
    send_measurement(32'd1);

    // Moderate gains and a small limit: drive the integral into its clamp
    drain();
    cfg_write(REG_SETPOINT, Q_ONE);
    cfg_write(REG_GAIN_P, 32'h0002_0000);
    cfg_write(REG_GAIN_I, 32'h0000_8000);
    cfg_write(REG_GAIN_D, 32'h0000_4000);
    cfg_write(REG_INTEGRAL_LIMIT, 32'h8003_0000);
    cfg_write(REG_SAMPLE_INTERVAL, 32'h0000_0080);
    cfg_release();
    repeat (4) send_measurement(32'hFFFC_0000);
    send_measurement(Q_ONE);
    send_measurement(32'h0003_0000);

    // Setpoint and interval writes keep the state; zero interval; spare indexes
    drain();
    cfg_write(REG_SETPOINT, 32'h0005_0000);
    cfg_write(REG_SAMPLE_INTERVAL, 32'hABCD_0000);
    cfg_write(REG_SPARE_LO, WORD_NEG);
    cfg_write(REG_SPARE_HI, WORD_NEG);
    cfg_release();
    send_measurement('0);
    send_measurement(32'h0002_0000);
    send_measurement(32'hFFFE_0000);

    // Extreme gains, widest limit and interval
    drain();
    cfg_write(REG_GAIN_P, WORD_MAX);
    cfg_write(REG_GAIN_I, WORD_MIN);
    cfg_write(REG_GAIN_D, WORD_MIN);
    cfg_write(REG_INTEGRAL_LIMIT, WORD_MAX);
    cfg_write(REG_SETPOINT, WORD_MIN);
    cfg_write(REG_SAMPLE_INTERVAL, 32'h0000_FFFF);
    cfg_release();
    send_measurement(WORD_MAX);
    send_measurement(WORD_MIN);
    send_measurement('0);
    send_measurement(WORD_MAX);

    // Opposite extremes, zero limit, smallest nonzero interval
    drain();
    cfg_write(REG_SETPOINT, WORD_MAX);
    cfg_write(REG_GAIN_P, WORD_MIN);
    cfg_write(REG_GAIN_I, WORD_MAX);
    cfg_write(REG_GAIN_D, WORD_MAX);
    cfg_write(REG_INTEGRAL_LIMIT, WORD_MIN);
    cfg_write(REG_SAMPLE_INTERVAL, 32'd1);
    cfg_release();
    send_measurement(WORD_MIN);
    send_measurement(WORD_MAX);
    send_measurement('0);

    // Random settings, each followed by a run of control ticks
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_settings();
      for (int n = 0; n < PHASE_ITEMS; n++) send_measurement(next_measurement());
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/pcu_pkg.sv
src/pcu_seq.sv
src/pcu_mul.sv
src/pcu_dp.sv
src/pid_controller_update.sv
bench/pcu_drive_checker.sv
bench/tb_pid_controller_update.sv
